FILE: sv/cdu_pkg.sv
package cdu_pkg;

   // field widths
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int YEAR_W   = 14;
   localparam int OFFSET_W = 23;
   localparam int DOY_W    = 9;
   localparam int WDAY_W   = 3;
   localparam int JD_W     = 24;
   localparam int NUM_W    = 28;
   localparam int RCP_W    = 32;
   localparam int DVS_W    = 21;

   // julian day limits and the fallback date
   localparam logic [JD_W-1:0] JD_MIN = 24'd1721426;
   localparam logic [JD_W-1:0] JD_MAX = 24'd5373484;
   localparam logic [JD_W-1:0] JD_DEF = 24'd2436700;
   localparam logic [MONTH_W-1:0] DEF_MONTH = 4'd5;
   localparam logic [DAY_W-1:0]   DEF_DAY   = 5'd11;
   localparam logic [YEAR_W-1:0]  DEF_YEAR  = 14'd1959;
   localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;

   // reciprocals for the constant divider
   localparam logic [RCP_W-1:0] RCP_100     = 32'((64'd1 << 32) / 64'd100);
   localparam logic [RCP_W-1:0] RCP_146097  = 32'((64'd1 << 32) / 64'd146097);
   localparam logic [RCP_W-1:0] RCP_1461001 = 32'((64'd1 << 32) / 64'd1461001);
   localparam logic [RCP_W-1:0] RCP_2447    = 32'((64'd1 << 32) / 64'd2447);
   localparam logic [RCP_W-1:0] RCP_7       = 32'((64'd1 << 32) / 64'd7);

   typedef enum logic [1:0] {
      OP_LOAD      = 2'd0,
      OP_ADD_DAYS  = 2'd1,
      OP_ADD_MONTH = 2'd2,
      OP_DIFF      = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DEFAULT = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      DIV_100,
      DIV_146097,
      DIV_1461001,
      DIV_2447,
      DIV_7
   } div_code_type;

   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_TJ_A,
      SQ_F1,
      SQ_F2,
      SQ_F3,
      SQ_TJ_C,
      SQ_TJ_Y,
      SQ_MOD7,
      SQ_OUT
   } seq_state_type;

   typedef struct packed {
      logic             start;
      div_code_type     code;
      logic [NUM_W-1:0] numer;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
      logic [DVS_W-1:0] rem;
   } div_rsp_type;

   typedef struct packed {
      opcode_type                  opcode;
      logic [MONTH_W-1:0]          month;
      logic [DAY_W-1:0]            day;
      logic [YEAR_W-1:0]           year;
      logic signed [OFFSET_W-1:0]  offset;
   } cmd_type;

   typedef struct packed {
      logic [MONTH_W-1:0]          month;
      logic [DAY_W-1:0]            day;
      logic [YEAR_W-1:0]           year;
      logic [DOY_W-1:0]            doy;
      logic [WDAY_W-1:0]           weekday;
      logic signed [OFFSET_W-1:0]  diff;
      status_type                  status;
   } result_type;

   // divisor for each divider code
   function automatic logic [DVS_W-1:0] div_const(div_code_type code);
      logic [DVS_W-1:0] val;
      case (code)
         DIV_100:     val = 21'd100;
         DIV_146097:  val = 21'd146097;
         DIV_1461001: val = 21'd1461001;
         DIV_2447:    val = 21'd2447;
         DIV_7:       val = 21'd7;
         default:     val = 21'd7;
      endcase
      return val;
   endfunction

   function automatic logic [RCP_W-1:0] div_recip(div_code_type code);
      logic [RCP_W-1:0] val;
      case (code)
         DIV_100:     val = RCP_100;
         DIV_146097:  val = RCP_146097;
         DIV_1461001: val = RCP_1461001;
         DIV_2447:    val = RCP_2447;
         DIV_7:       val = RCP_7;
         default:     val = RCP_7;
      endcase
      return val;
   endfunction

   // 367 * (shifted month) / 12, shifted month counts from march
   function automatic logic [8:0] month_term(logic [MONTH_W-1:0] m);
      logic [8:0] val;
      case (m)
         4'd0:    val = 9'd305;
         4'd1:    val = 9'd336;
         4'd2:    val = 9'd367;
         4'd3:    val = 9'd30;
         4'd4:    val = 9'd61;
         4'd5:    val = 9'd91;
         4'd6:    val = 9'd122;
         4'd7:    val = 9'd152;
         4'd8:    val = 9'd183;
         4'd9:    val = 9'd214;
         4'd10:   val = 9'd244;
         4'd11:   val = 9'd275;
         4'd12:   val = 9'd305;
         4'd13:   val = 9'd336;
         4'd14:   val = 9'd367;
         default: val = 9'd397;
      endcase
      return val;
   endfunction

   // 2447 * j / 80
   function automatic logic [8:0] day_term(logic [3:0] j);
      logic [8:0] val;
      case (j)
         4'd0:    val = 9'd0;
         4'd1:    val = 9'd30;
         4'd2:    val = 9'd61;
         4'd3:    val = 9'd91;
         4'd4:    val = 9'd122;
         4'd5:    val = 9'd152;
         4'd6:    val = 9'd183;
         4'd7:    val = 9'd214;
         4'd8:    val = 9'd244;
         4'd9:    val = 9'd275;
         4'd10:   val = 9'd305;
         4'd11:   val = 9'd336;
         4'd12:   val = 9'd367;
         4'd13:   val = 9'd397;
         4'd14:   val = 9'd428;
         default: val = 9'd458;
      endcase
      return val;
   endfunction

endpackage

FILE: sv/calendar_date_unit.sv
// channel   dir   signals                        contents
// req       in    req_tvalid/tready/tdata/tuser  one command
// rsp       out   rsp_tvalid/tready/tdata        date after the command
//
// a command makes up to seven passes through the shared constant divider,
// plus dispatch and handoff
// req_tready is high only while the sequencer is idle
// the finished result sits in the rsp register until taken
// synchronous reset restores May 11, 1959 and clears both channels
module calendar_date_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // month_in, day_in, year_in, day_offset
   input  logic [1:0]  req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata   // month_out, day_out, year_out, day_of_year,
                                   // weekday, days_between, status
);

   cdu_pkg::cmd_type      cmd;
   cdu_pkg::result_type   result;
   cdu_pkg::div_req_type  div_req;
   cdu_pkg::div_rsp_type  div_rsp;
   logic                  seq_idle;
   logic                  res_valid;
   logic                  res_ack;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [63:0]           rsp_tdata_ff;

   // command unpacking
   always_comb begin
      cmd.opcode = cdu_pkg::opcode_type'(req_tuser);
      cmd.month  = req_tdata[3:0];
      cmd.day    = req_tdata[8:4];
      cmd.year   = req_tdata[22:9];
      cmd.offset = $signed(req_tdata[45:23]);
   end

   assign req_tready = seq_idle;

   cdu_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid && seq_idle),
      .cmd       (cmd),
      .idle      (seq_idle),
      .res_valid (res_valid),
      .res_ack   (res_ack),
      .result    (result),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   cdu_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // output register
   assign res_ack       = res_valid && (!rsp_tvalid_ff || rsp_tready);
   assign rsp_tvalid_in = res_ack ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ack) begin
         rsp_tdata_ff <= {4'b0000, result.status, result.diff, result.weekday,
                          result.doy, result.year, result.day, result.month};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

FILE: sv/cdu_divider.sv
module cdu_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  cdu_pkg::div_req_type  div_req,
   output cdu_pkg::div_rsp_type  div_rsp
);

   logic [cdu_pkg::NUM_W-1:0]     numer_ff;
   cdu_pkg::div_code_type         code_ff;
   logic [59:0]                   prod_ff;
   logic [59:0]                   prod_in;
   logic                          stage1_ff;
   logic                          stage2_ff;
   logic                          done_ff;
   logic [cdu_pkg::NUM_W-1:0]     quot_ff;
   logic [cdu_pkg::NUM_W-1:0]     quot_in;
   logic [cdu_pkg::DVS_W-1:0]     rem_ff;
   logic [cdu_pkg::DVS_W-1:0]     rem_in;
   logic [cdu_pkg::NUM_W-1:0]     quot_est;
   logic [cdu_pkg::DVS_W-1:0]     divisor;
   logic [48:0]                   back;
   logic [cdu_pkg::NUM_W-1:0]     rem_wide;
   logic [cdu_pkg::DVS_W:0]       rem_est;

   // stage tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= div_req.start;
         stage2_ff <= stage1_ff;
         done_ff   <= stage2_ff;
      end
   end

   // operand capture
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         numer_ff <= div_req.numer;
         code_ff  <= div_req.code;
      end
   end

   // reciprocal multiply
   assign prod_in = 60'(numer_ff) * 60'(cdu_pkg::div_recip(code_ff));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // back multiply and one correction step
   always_comb begin
      quot_est = prod_ff[59:32];
      divisor  = cdu_pkg::div_const(code_ff);
      back     = 49'(quot_est) * 49'(divisor);
      rem_wide = numer_ff - back[cdu_pkg::NUM_W-1:0];
      rem_est  = rem_wide[cdu_pkg::DVS_W:0];
      if (rem_est >= {1'b0, divisor}) begin
         quot_in = quot_est + 28'd1;
         rem_in  = 21'(rem_est - {1'b0, divisor});
      end else begin
         quot_in = quot_est;
         rem_in  = rem_est[cdu_pkg::DVS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

   // remainder always below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < cdu_pkg::div_const(code_ff))
      else $error("divider remainder not reduced");

   // done follows a start through the stage1 and stage2 registers
   a_done_timing: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> ##1 done_ff == 1'b0 ##1 done_ff)
      else $error("divider done timing");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      stage1_ff |-> !div_req.start)
      else $error("divider restarted while busy");

endmodule

FILE: sv/cdu_seq.sv
module cdu_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  cdu_pkg::cmd_type      cmd,
   output logic                  idle,
   output logic                  res_valid,
   input  logic                  res_ack,
   output cdu_pkg::result_type   result,
   output cdu_pkg::div_req_type  div_req,
   input  cdu_pkg::div_rsp_type  div_rsp
);

   cdu_pkg::seq_state_type         state_ff, state_in;
   logic                           busy_ff, busy_in;
   cdu_pkg::opcode_type            op_ff, op_in;
   cdu_pkg::status_type            status_ff, status_in;
   logic [cdu_pkg::MONTH_W-1:0]    gm_ff, gm_in;
   logic [cdu_pkg::DAY_W-1:0]      gd_ff, gd_in;
   logic [cdu_pkg::YEAR_W-1:0]     gy_ff, gy_in;
   logic signed [cdu_pkg::OFFSET_W-1:0] off_ff, off_in;
   logic [cdu_pkg::MONTH_W-1:0]    cm_ff, cm_in;
   logic [cdu_pkg::DAY_W-1:0]      cd_ff, cd_in;
   logic [cdu_pkg::YEAR_W-1:0]     cy_ff, cy_in;
   logic [cdu_pkg::JD_W-1:0]       jd_ff, jd_in;
   logic [cdu_pkg::JD_W-1:0]       jdg_ff, jdg_in;
   logic [cdu_pkg::JD_W-1:0]       jdc_ff, jdc_in;
   logic [7:0]                     n_ff, n_in;
   logic [15:0]                    l_ff, l_in;
   logic [6:0]                     i_ff, i_in;
   logic [cdu_pkg::DOY_W-1:0]      doy_ff, doy_in;
   logic [cdu_pkg::WDAY_W-1:0]     wday_ff, wday_in;

   // to_jd datapath
   logic [cdu_pkg::MONTH_W-1:0]    tm;
   logic [cdu_pkg::DAY_W-1:0]      td;
   logic [cdu_pkg::YEAR_W-1:0]     ty;
   logic [14:0]                    ty_adj;
   logic [25:0]                    yr_term;
   logic [9:0]                     cent_term;
   logic [25:0]                    tj_sum;
   logic [cdu_pkg::JD_W-1:0]       tj_jd;
   logic signed [25:0]             day_sum;
   logic                           day_ok;

   // from_jd datapath
   logic [24:0]                    l0;
   logic [25:0]                    n_term;
   logic [17:0]                    i_term;
   logic [16:0]                    l2;
   logic [3:0]                     fj_j;
   logic                           fj_lq;
   logic [cdu_pkg::MONTH_W-1:0]    fj_m;
   logic [9:0]                     fj_k;
   logic [16:0]                    fj_y;
   logic                           trip_ok;
   logic [4:0]                     next_m;
   logic [9:0]                     feb_len;
   logic                           compute;

   // operand select for the date to julian day conversion
   always_comb begin
      tm = cm_ff;
      td = cd_ff;
      ty = cy_ff;
      case (state_ff)
         cdu_pkg::SQ_TJ_A: begin
            case (op_ff)
               cdu_pkg::OP_LOAD, cdu_pkg::OP_DIFF: begin
                  tm = gm_ff;
                  td = gd_ff;
                  ty = gy_ff;
               end
               cdu_pkg::OP_ADD_MONTH: begin
                  tm = cm_ff + 4'd1;
               end
               default: begin
                  tm = cm_ff;
               end
            endcase
         end
         cdu_pkg::SQ_TJ_Y: begin
            tm = 4'd1;
            td = 5'd1;
         end
         default: begin
            tm = cm_ff;
         end
      endcase
   end

   // julian day from the selected date and the century quotient
   always_comb begin
      ty_adj    = 15'(ty) + 15'd4800 - ((tm <= 4'd2) ? 15'd1 : 15'd0);
      yr_term   = 26'(ty_adj) * 26'd1461;
      cent_term = ((10'(div_rsp.quot[7:0]) + 10'd1) * 10'd3) >> 2;
      tj_sum    = 26'(td) + (yr_term >> 2) + 26'(cdu_pkg::month_term(tm))
                - 26'(cent_term) - 26'd32075;
      tj_jd     = tj_sum[cdu_pkg::JD_W-1:0];
      day_sum   = $signed({2'b00, tj_jd}) + 26'(off_ff);
      day_ok    = !day_sum[25] && (day_sum[24:0] >= 25'(cdu_pkg::JD_MIN))
                && (day_sum[24:0] <= 25'(cdu_pkg::JD_MAX));
   end

   // julian day back to a date
   always_comb begin
      l0      = 25'(jd_ff) + 25'd68569;
      n_term  = 26'(div_rsp.quot[7:0]) * 26'd146097 + 26'd3;
      i_term  = 18'(div_rsp.quot[6:0]) * 18'd1461;
      l2      = 17'(l_ff) - 17'(i_term >> 2) + 17'd31;
      fj_j    = div_rsp.quot[3:0];
      fj_lq   = (fj_j >= 4'd11);
      fj_m    = fj_j + 4'd2 - (fj_lq ? 4'd12 : 4'd0);
      fj_k    = l_ff[9:0] - 10'(cdu_pkg::day_term(fj_j));
      fj_y    = 17'(n_ff) * 17'd100 + 17'(i_ff) + 17'(fj_lq) - 17'd4900;
      trip_ok = (fj_m == gm_ff) && (fj_k == 10'(gd_ff)) && (fj_y == 17'(gy_ff));
      next_m  = 5'(cm_ff) + 5'd1;
      feb_len = 10'(cd_ff) - fj_k;
   end

   // divider requests
   always_comb begin
      compute = (state_ff != cdu_pkg::SQ_IDLE) && (state_ff != cdu_pkg::SQ_OUT);
      div_req.start = compute && !busy_ff;
      div_req.code  = cdu_pkg::DIV_100;
      div_req.numer = 28'(ty_adj);
      case (state_ff)
         cdu_pkg::SQ_F1: begin
            div_req.code  = cdu_pkg::DIV_146097;
            div_req.numer = {1'b0, l0, 2'b00};
         end
         cdu_pkg::SQ_F2: begin
            div_req.code  = cdu_pkg::DIV_1461001;
            div_req.numer = (28'(l_ff) + 28'd1) * 28'd4000;
         end
         cdu_pkg::SQ_F3: begin
            div_req.code  = cdu_pkg::DIV_2447;
            div_req.numer = 28'(l_ff) * 28'd80;
         end
         cdu_pkg::SQ_MOD7: begin
            div_req.code  = cdu_pkg::DIV_7;
            div_req.numer = 28'(jdc_ff);
         end
         default: begin
            div_req.code  = cdu_pkg::DIV_100;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      busy_in   = div_req.start ? 1'b1 : (div_rsp.done ? 1'b0 : busy_ff);
      op_in     = op_ff;
      status_in = status_ff;
      gm_in     = gm_ff;
      gd_in     = gd_ff;
      gy_in     = gy_ff;
      off_in    = off_ff;
      cm_in     = cm_ff;
      cd_in     = cd_ff;
      cy_in     = cy_ff;
      jd_in     = jd_ff;
      jdg_in    = jdg_ff;
      jdc_in    = jdc_ff;
      n_in      = n_ff;
      l_in      = l_ff;
      i_in      = i_ff;
      doy_in    = doy_ff;
      wday_in   = wday_ff;
      case (state_ff)
         cdu_pkg::SQ_IDLE: begin
            if (cmd_valid) begin
               op_in     = cmd.opcode;
               gm_in     = cmd.month;
               gd_in     = cmd.day;
               gy_in     = cmd.year;
               off_in    = cmd.offset;
               status_in = cdu_pkg::ST_OK;
               state_in  = cdu_pkg::SQ_TJ_A;
            end
         end
         cdu_pkg::SQ_TJ_A: begin
            if (div_rsp.done) begin
               jd_in    = tj_jd;
               jdg_in   = tj_jd;
               state_in = cdu_pkg::SQ_F1;
               if (op_ff == cdu_pkg::OP_ADD_DAYS) begin
                  jd_in = day_sum[cdu_pkg::JD_W-1:0];
                  if (!day_ok) begin
                     status_in = cdu_pkg::ST_RANGE;
                     state_in  = cdu_pkg::SQ_TJ_C;
                  end
               end
            end
         end
         cdu_pkg::SQ_F1: begin
            if (div_rsp.done) begin
               n_in     = div_rsp.quot[7:0];
               l_in     = 16'(l0 - 25'(n_term >> 2));
               state_in = cdu_pkg::SQ_F2;
            end
         end
         cdu_pkg::SQ_F2: begin
            if (div_rsp.done) begin
               i_in     = div_rsp.quot[6:0];
               l_in     = l2[15:0];
               state_in = cdu_pkg::SQ_F3;
            end
         end
         cdu_pkg::SQ_F3: begin
            if (div_rsp.done) begin
               state_in = cdu_pkg::SQ_TJ_C;
               case (op_ff)
                  cdu_pkg::OP_ADD_DAYS: begin
                     cm_in = fj_m;
                     cd_in = fj_k[4:0];
                     cy_in = fj_y[13:0];
                  end
                  cdu_pkg::OP_ADD_MONTH: begin
                     // day overflow clamps to end of february or day 30
                     if (fj_y > 17'(cdu_pkg::MAX_YEAR)) begin
                        status_in = cdu_pkg::ST_RANGE;
                     end else if (5'(fj_m) > next_m) begin
                        cy_in = fj_y[13:0];
                        if (fj_m == 4'd3) begin
                           cm_in = 4'd2;
                           cd_in = (feb_len == 10'd29) ? 5'd29 : 5'd28;
                        end else begin
                           cm_in = next_m[3:0];
                           cd_in = 5'd30;
                        end
                     end else begin
                        cm_in = fj_m;
                        cd_in = fj_k[4:0];
                        cy_in = fj_y[13:0];
                     end
                  end
                  default: begin
                     // given date checked by round trip
                     if (!trip_ok) begin
                        status_in = cdu_pkg::ST_DEFAULT;
                        jdg_in    = cdu_pkg::JD_DEF;
                        if (op_ff == cdu_pkg::OP_LOAD) begin
                           cm_in = cdu_pkg::DEF_MONTH;
                           cd_in = cdu_pkg::DEF_DAY;
                           cy_in = cdu_pkg::DEF_YEAR;
                        end
                     end else if (gy_ff == '0 || gy_ff > cdu_pkg::MAX_YEAR) begin
                        status_in = cdu_pkg::ST_RANGE;
                     end else if (op_ff == cdu_pkg::OP_LOAD) begin
                        cm_in = gm_ff;
                        cd_in = gd_ff;
                        cy_in = gy_ff;
                     end
                  end
               endcase
            end
         end
         cdu_pkg::SQ_TJ_C: begin
            if (div_rsp.done) begin
               jdc_in   = tj_jd;
               state_in = cdu_pkg::SQ_TJ_Y;
            end
         end
         cdu_pkg::SQ_TJ_Y: begin
            if (div_rsp.done) begin
               doy_in   = 9'(jdc_ff - tj_jd + 24'd1);
               state_in = cdu_pkg::SQ_MOD7;
            end
         end
         cdu_pkg::SQ_MOD7: begin
            if (div_rsp.done) begin
               wday_in  = div_rsp.rem[2:0];
               state_in = cdu_pkg::SQ_OUT;
            end
         end
         cdu_pkg::SQ_OUT: begin
            if (res_ack) begin
               state_in = cdu_pkg::SQ_IDLE;
            end
         end
         default: begin
            state_in = cdu_pkg::SQ_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdu_pkg::SQ_IDLE;
         busy_ff  <= 1'b0;
         cm_ff    <= cdu_pkg::DEF_MONTH;
         cd_ff    <= cdu_pkg::DEF_DAY;
         cy_ff    <= cdu_pkg::DEF_YEAR;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         cm_ff    <= cm_in;
         cd_ff    <= cd_in;
         cy_ff    <= cy_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      status_ff <= status_in;
      gm_ff     <= gm_in;
      gd_ff     <= gd_in;
      gy_ff     <= gy_in;
      off_ff    <= off_in;
      jd_ff     <= jd_in;
      jdg_ff    <= jdg_in;
      jdc_ff    <= jdc_in;
      n_ff      <= n_in;
      l_ff      <= l_in;
      i_ff      <= i_in;
      doy_ff    <= doy_in;
      wday_ff   <= wday_in;
   end

   // result transaction
   always_comb begin
      idle           = (state_ff == cdu_pkg::SQ_IDLE);
      res_valid      = (state_ff == cdu_pkg::SQ_OUT);
      result.month   = cm_ff;
      result.day     = cd_ff;
      result.year    = cy_ff;
      result.doy     = doy_ff;
      result.weekday = wday_ff;
      result.status  = status_ff;
      if (op_ff == cdu_pkg::OP_DIFF && status_ff != cdu_pkg::ST_RANGE) begin
         result.diff = $signed(23'(jdg_ff - jdc_ff));
      end else begin
         result.diff = '0;
      end
   end

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> busy_ff)
      else $error("divider result without request");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      cm_ff >= 4'd1 && cm_ff <= 4'd12)
      else $error("current month out of range");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      cy_ff >= 14'd1 && cy_ff <= cdu_pkg::MAX_YEAR)
      else $error("current year out of range");

   a_range_no_diff: assert property (@(posedge clock) disable iff (reset)
      (res_valid && status_ff == cdu_pkg::ST_RANGE) |-> result.diff == '0)
      else $error("difference given on ignored command");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_ack) |=> res_valid && $stable(cm_ff) && $stable(status_ff))
      else $error("result dropped before it was taken");

endmodule
